// File: src/srgb_to_lab_converter_defines.svh
// ----------------------------------------------------------------------------
// srgb_to_lab_converter_defines.svh
// Assertion macros shared by the sRGB to Lab converter RTL.
// ----------------------------------------------------------------------------
`ifndef SRGB_TO_LAB_CONVERTER_DEFINES_SVH
`define SRGB_TO_LAB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS

// Labeled assertion on an explicit clock and active-low reset
`define SLAB_ASSERT_AT(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) \
		else $error("slab assertion failed");

// Labeled assertion on the block clock and reset
`define SLAB_ASSERT(label, prop) `SLAB_ASSERT_AT(label, clk, arst_n, prop)

`else

`define SLAB_ASSERT_AT(label, clock, rst_n, prop)
`define SLAB_ASSERT(label, prop)

`endif

`endif

// File: src/slab_pkg.sv
// ----------------------------------------------------------------------------
// slab_pkg
// Types, constants and the linearization table of the sRGB to Lab converter.
// ----------------------------------------------------------------------------
package slab_pkg;

	// Q16 unsigned value, one extra bit so that 1.0 and a little above fit
	typedef logic [16:0] q16_t;

	// sRGB linearization table, one Q16 entry per 8-bit code
	typedef logic [255:0][16:0] lin_rom_t;

	// Pipeline lengths of the two sections
	localparam int XYZ_STAGES  = 6;
	localparam int LABF_STAGES = 17;
	localparam int CBRT_BITS   = 17;

	// Fraction bits of the internal Lab values
	localparam int QF = 16;

	// White-point normalization: divisor, reciprocal and shift per channel
	localparam longint unsigned DIV_X = 64'd95047;
	localparam longint unsigned DIV_Y = 64'd10000;
	localparam longint unsigned DIV_Z = 64'd108883;
	localparam int SHIFT_X = 33;
	localparam int SHIFT_Y = 30;
	localparam int SHIFT_Z = 33;
	localparam longint unsigned RECIP_X = (64'd1 << SHIFT_X) / DIV_X;
	localparam longint unsigned RECIP_Y = (64'd1 << SHIFT_Y) / DIV_Y;
	localparam longint unsigned RECIP_Z = (64'd1 << SHIFT_Z) / DIV_Z;

	// Linear segment of the Lab f() function
	localparam int LIN_SMALL_LIMIT = 581;
	localparam int LIN_SHIFT       = 23;
	localparam int LIN_DIV         = 1000;
	localparam longint unsigned LIN_RECIP = (64'd1 << LIN_SHIFT) / 64'd1000;
	localparam int LIN_OFFSET      = 9039;

	// Build the linearization table at elaboration
	function automatic lin_rom_t build_lin_rom();
		lin_rom_t rom;
		longint unsigned t, lo, hi, mid, a, b, p, t2, s2, y;
		for (int v = 0; v < 256; v++) begin
			if (v <= 10) begin
				rom[v] = 17'((64'(v) * 64'd6553600 + 64'd164730) / 64'd329460);
			end else begin
				t = (((64'd1000 * 64'(v) + 64'd14025) << 24) + 64'd134512) / 64'd269025;
				lo = 64'd0;
				hi = 64'd1 << 24;
				// fifth root of t in Q24 by bisection
				while (lo < hi) begin
					mid = (lo + hi + 64'd1) >> 1;
					a = (mid * mid) >> 24;
					b = (a * a) >> 24;
					p = (b * mid) >> 24;
					if (p <= t) begin
						lo = mid;
					end else begin
						hi = mid - 64'd1;
					end
				end
				t2 = (t * t) >> 24;
				s2 = (lo * lo) >> 24;
				y = (t2 * s2) >> 24;
				rom[v] = 17'((y + 64'd128) >> 8);
			end
		end
		return rom;
	endfunction

endpackage

// File: src/srgb_to_lab_converter.sv
// ----------------------------------------------------------------------------
// srgb_to_lab_converter
// sRGB pixel to CIELAB (D65) in fixed point, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while not stalled and returns L*, a*, b* with
// FRAC_BITS fraction bits through 6 stages for linearization and XYZ
// normalization, 17 stages for the bit-per-stage cube root of f(), and
// one stage for the Lab combination, rounding and saturation. The whole
// pipeline holds while a finished result is stalled at the output, so
// pixel_stall follows lab_stall only when the last stage holds a result.
`include "srgb_to_lab_converter_defines.svh"

module srgb_to_lab_converter #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	output logic               lab_valid,
	input  logic               lab_stall,
	output logic [14:0]        lightness,
	output logic signed [15:0] green_red,
	output logic signed [15:0] blue_yellow
);
	import slab_pkg::*;

	localparam int DEPTH = XYZ_STAGES + LABF_STAGES + 1;
	localparam int S     = QF - FRAC_BITS;
	localparam int LMAX_FULL = 100 << FRAC_BITS;
	localparam int LMAX_INT  = (LMAX_FULL > 32767) ? 32767 : LMAX_FULL;
	localparam logic [14:0] LMAX = 15'(LMAX_INT);
	localparam logic signed [27:0] HALF = 28'sd1 <<< (S - 1);

	logic             adv;
	logic [DEPTH-1:0] valid_s;
	q16_t             xn, yn, zn, fx, fy, fz;

	logic signed [27:0] fxs, fys, fzs;
	logic signed [27:0] l_raw, a_raw, b_raw, l_rnd, a_rnd, b_rnd;
	logic [14:0]        l_sat;
	logic signed [15:0] a_sat, b_sat;
	logic [14:0]        lab_l_s24;
	logic signed [15:0] lab_a_s24, lab_b_s24;

	// Global advance: hold only when the finished result is not taken
	assign adv         = !(valid_s[DEPTH-1] && lab_stall);
	assign pixel_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[DEPTH-2:0], pixel_valid};
		end
	end

	slab_xyz u_xyz (
		.clk    (clk),
		.adv    (adv),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.x_norm (xn),
		.y_norm (yn),
		.z_norm (zn)
	);

	slab_labf u_fx (.clk(clk), .adv(adv), .q(xn), .f(fx));
	slab_labf u_fy (.clk(clk), .adv(adv), .q(yn), .f(fy));
	slab_labf u_fz (.clk(clk), .adv(adv), .q(zn), .f(fz));

	// Lab combination, round half up, saturate
	always_comb begin
		fxs   = $signed({11'd0, fx});
		fys   = $signed({11'd0, fy});
		fzs   = $signed({11'd0, fz});
		l_raw = fys * 28'sd116 - (28'sd16 <<< QF);
		a_raw = (fxs - fys) * 28'sd500;
		b_raw = (fys - fzs) * 28'sd200;
		l_rnd = (l_raw + HALF) >>> S;
		a_rnd = (a_raw + HALF) >>> S;
		b_rnd = (b_raw + HALF) >>> S;
		if (l_rnd < 28'sd0) begin
			l_sat = '0;
		end else if (l_rnd > $signed({13'd0, LMAX})) begin
			l_sat = LMAX;
		end else begin
			l_sat = l_rnd[14:0];
		end
		if (a_rnd < -28'sd32768) begin
			a_sat = 16'sh8000;
		end else if (a_rnd > 28'sd32767) begin
			a_sat = 16'sh7fff;
		end else begin
			a_sat = a_rnd[15:0];
		end
		if (b_rnd < -28'sd32768) begin
			b_sat = 16'sh8000;
		end else if (b_rnd > 28'sd32767) begin
			b_sat = 16'sh7fff;
		end else begin
			b_sat = b_rnd[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lab_l_s24 <= l_sat;
			lab_a_s24 <= a_sat;
			lab_b_s24 <= b_sat;
		end
	end

	assign lab_valid   = valid_s[DEPTH-1];
	assign lightness   = lab_l_s24;
	assign green_red   = lab_a_s24;
	assign blue_yellow = lab_b_s24;

	// Checks
	`SLAB_ASSERT(a_enter_first_stage, (pixel_valid && !pixel_stall) |=> valid_s[0])
	`SLAB_ASSERT(a_stall_freezes_pipe, (lab_valid && lab_stall) |=> $stable(valid_s))
	`SLAB_ASSERT(a_lightness_range, lab_valid |-> (lightness <= LMAX))

endmodule

// File: src/slab_xyz.sv
// ----------------------------------------------------------------------------
// slab_xyz
// Linearizes the sRGB codes and maps them to white-normalized XYZ in Q16.
// ----------------------------------------------------------------------------
module slab_xyz (
	input  logic          clk,
	input  logic          adv,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	output slab_pkg::q16_t x_norm,
	output slab_pkg::q16_t y_norm,
	output slab_pkg::q16_t z_norm
);
	import slab_pkg::*;

	localparam lin_rom_t LIN_ROM = build_lin_rom();
	localparam longint unsigned DIV   [3] = '{DIV_X, DIV_Y, DIV_Z};
	localparam longint unsigned RECIP [3] = '{RECIP_X, RECIP_Y, RECIP_Z};
	localparam int              SHIFT [3] = '{SHIFT_X, SHIFT_Y, SHIFT_Z};

	logic [7:0]  code_s1 [3];
	q16_t        lin_s2  [3];
	logic [33:0] n_s3    [3];
	logic [33:0] n_s4    [3];
	q16_t        q0_s4   [3];
	logic [33:0] n_s5    [3];
	q16_t        q0_s5   [3];
	logic [33:0] prod_s5 [3];
	q16_t        q_s6    [3];

	logic [33:0] n_c    [3];
	logic [50:0] recm_c [3];

	// Matrix sums, scaled so that one constant divide normalizes each row
	always_comb begin
		n_c[0] = (34'(lin_s2[0]) * 34'd4124 + 34'(lin_s2[1]) * 34'd3576
			+ 34'(lin_s2[2]) * 34'd1805) * 34'd10;
		n_c[1] = 34'(lin_s2[0]) * 34'd2126 + 34'(lin_s2[1]) * 34'd7152
			+ 34'(lin_s2[2]) * 34'd722;
		n_c[2] = (34'(lin_s2[0]) * 34'd193 + 34'(lin_s2[1]) * 34'd1192
			+ 34'(lin_s2[2]) * 34'd9505) * 34'd10;
		for (int c = 0; c < 3; c++) begin
			recm_c[c] = 51'(n_s3[c]) * 51'(RECIP[c]);
		end
	end

	// Stages: input, table, sums, reciprocal estimate, back product, correction
	always_ff @(posedge clk) begin
		if (adv) begin
			code_s1[0] <= red;
			code_s1[1] <= green;
			code_s1[2] <= blue;
			for (int c = 0; c < 3; c++) begin
				lin_s2[c]  <= LIN_ROM[code_s1[c]];
				n_s3[c]    <= n_c[c];
				n_s4[c]    <= n_s3[c];
				q0_s4[c]   <= 17'(recm_c[c] >> SHIFT[c]);
				n_s5[c]    <= n_s4[c];
				q0_s5[c]   <= q0_s4[c];
				prod_s5[c] <= 34'(q0_s4[c]) * 34'(DIV[c]);
				// estimate is at most one low
				q_s6[c]    <= q0_s5[c] + 17'((n_s5[c] - prod_s5[c]) >= 34'(DIV[c]));
			end
		end
	end

	assign x_norm = q_s6[0];
	assign y_norm = q_s6[1];
	assign z_norm = q_s6[2];

endmodule

// File: src/slab_labf.sv
// ----------------------------------------------------------------------------
// slab_labf
// Lab f() of one normalized Q16 channel: pipelined cube root, linear segment.
// ----------------------------------------------------------------------------
module slab_labf (
	input  logic           clk,
	input  logic           adv,
	input  slab_pkg::q16_t q,
	output slab_pkg::q16_t f
);
	import slab_pkg::*;

	localparam int W  = 56;
	localparam int NS = LABF_STAGES;

	// Cube root, one result bit per stage, remainder kept as n - res^3
	q16_t        res_s  [1:NS];
	logic [33:0] res2_s [1:NS];
	logic [48:0] rem_s  [1:NS];
	logic        small_s [1:NS];

	q16_t        in_res  [1:NS];
	logic [33:0] in_res2 [1:NS];
	logic [48:0] in_rem  [1:NS];
	logic [W-1:0] term   [1:NS];
	logic        take    [1:NS];

	// Linear segment path
	logic [22:0] lin_m_s1, lin_m_s2, lin_m_s3;
	logic [12:0] lin_q0_s2, lin_q0_s3;
	logic [22:0] lin_prod_s3;
	q16_t        lin_f_s [4:NS];
	logic [45:0] lin_recm;

	// Per-stage trial: does (res + 2^i)^3 still fit below n
	always_comb begin
		in_res[1]  = '0;
		in_res2[1] = '0;
		in_rem[1]  = {q, 32'd0};
		for (int k = 2; k <= NS; k++) begin
			in_res[k]  = res_s[k-1];
			in_res2[k] = res2_s[k-1];
			in_rem[k]  = rem_s[k-1];
		end
		for (int k = 1; k <= NS; k++) begin
			term[k] = ((W'(in_res2[k]) * W'(3)) << (CBRT_BITS - k))
				+ ((W'(in_res[k]) * W'(3)) << (2 * (CBRT_BITS - k)))
				+ (W'(1) << (3 * (CBRT_BITS - k)));
			take[k] = term[k] <= W'(in_rem[k]);
		end
		lin_recm = 46'(lin_m_s1) * 46'(LIN_RECIP);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 1; k <= NS; k++) begin
				if (take[k]) begin
					res_s[k]  <= in_res[k] | (17'(1) << (CBRT_BITS - k));
					res2_s[k] <= in_res2[k] + (34'(in_res[k]) << (CBRT_BITS - k + 1))
						+ (34'(1) << (2 * (CBRT_BITS - k)));
					rem_s[k]  <= 49'(W'(in_rem[k]) - term[k]);
				end else begin
					res_s[k]  <= in_res[k];
					res2_s[k] <= in_res2[k];
					rem_s[k]  <= in_rem[k];
				end
			end
			small_s[1] <= q < 17'(LIN_SMALL_LIMIT);
			for (int k = 2; k <= NS; k++) begin
				small_s[k] <= small_s[k-1];
			end
			// (7787 q + 500) / 1000 + 16/116 by reciprocal and correction
			lin_m_s1    <= 23'(q[9:0]) * 23'd7787 + 23'd500;
			lin_m_s2    <= lin_m_s1;
			lin_q0_s2   <= 13'(lin_recm >> LIN_SHIFT);
			lin_m_s3    <= lin_m_s2;
			lin_q0_s3   <= lin_q0_s2;
			lin_prod_s3 <= 23'(lin_q0_s2) * 23'(LIN_DIV);
			lin_f_s[4]  <= 17'(lin_q0_s3)
				+ 17'((lin_m_s3 - lin_prod_s3) >= 23'(LIN_DIV)) + 17'(LIN_OFFSET);
			for (int k = 5; k <= NS; k++) begin
				lin_f_s[k] <= lin_f_s[k-1];
			end
		end
	end

	assign f = small_s[NS] ? lin_f_s[NS] : res_s[NS];

endmodule
